// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the link-gated dual byte FIFO RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LGDBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LGDBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lgdbf_pkg.sv -----
// Package of the link-gated dual byte FIFO: sizes, codes, types and the owner function.
// Depends on nothing; used by the interfaces, the store RAM and the top level.
package lgdbf_pkg;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);

    localparam int ACT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int AMT_W   = 9;
    localparam int LVL_W   = 9;
    localparam int PHASE_W = 3;
    localparam int OWNER_W = 2;
    localparam int CNT_W   = 32;

    // Common width for transmit length compares, and for head plus offset sums.
    localparam int TX_CW = (TX_FW > AMT_W) ? TX_FW : AMT_W;
    localparam int TX_SW = ((TX_AW > TX_CW) ? TX_AW : TX_CW) + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ENABLE    = 5'd0,
        ACT_DISABLE   = 5'd1,
        ACT_DISC      = 5'd2,
        ACT_CONNECT   = 5'd3,
        ACT_ERROR     = 5'd4,
        ACT_RX_PUSH   = 5'd5,
        ACT_CONSOLE   = 5'd6,
        ACT_TEST      = 5'd7,
        ACT_BEGIN     = 5'd8,
        ACT_END       = 5'd9,
        ACT_READ_CON  = 5'd10,
        ACT_READ_TEST = 5'd11,
        ACT_READ_XFER = 5'd12,
        ACT_TX_PUSH   = 5'd13,
        ACT_EXACT     = 5'd14,
        ACT_PEEK      = 5'd15,
        ACT_DONE      = 5'd16
    } action_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF   = 3'd0,
        PH_READY = 3'd1,
        PH_DISC  = 3'd2,
        PH_CONN  = 3'd3,
        PH_ERROR = 3'd4
    } link_phase_t;

    typedef enum logic [OWNER_W-1:0] {
        OWN_NONE    = 2'd0,
        OWN_CONSOLE = 2'd1,
        OWN_TEST    = 2'd2,
        OWN_XFER    = 2'd3
    } owner_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic enabled;
        logic connected;
        logic transfer;
        logic console;
        logic test;
    } mode_t;

    // Receive owner by priority: transfer, then test terminal, then console.
    function automatic owner_t owner_of(input mode_t m);
        owner_t o;
        if (!m.enabled || !m.connected) begin
            o = OWN_NONE;
        end else if (m.transfer) begin
            o = OWN_XFER;
        end else if (m.test) begin
            o = OWN_TEST;
        end else if (m.console) begin
            o = OWN_CONSOLE;
        end else begin
            o = OWN_NONE;
        end
        return o;
    endfunction

endpackage

// ----- hw/rtl/lgdbf_req_if.sv -----
// Request channel of the link-gated dual byte FIFO: valid, ready and the request fields.
// Depends on lgdbf_pkg for the field widths.
interface lgdbf_req_if;
    logic                          valid;
    logic                          ready;
    logic [lgdbf_pkg::ACT_W-1:0]   action;
    logic                          flag;
    logic [lgdbf_pkg::BYTE_W-1:0]  data_byte;
    logic [lgdbf_pkg::AMT_W-1:0]   amount;

    modport source (output valid, action, flag, data_byte, amount, input ready);
    modport sink   (input valid, action, flag, data_byte, amount, output ready);
endinterface

// ----- hw/rtl/lgdbf_rsp_if.sv -----
// Response channel of the link-gated dual byte FIFO: valid, ready, status and counters.
// Depends on lgdbf_pkg for the field widths.
interface lgdbf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [lgdbf_pkg::BYTE_W-1:0]    data_out;
    logic [lgdbf_pkg::PHASE_W-1:0]   link_state;
    logic [lgdbf_pkg::OWNER_W-1:0]   rx_user;
    logic [lgdbf_pkg::LVL_W-1:0]     rx_level;
    logic [lgdbf_pkg::LVL_W-1:0]     tx_level;
    logic [lgdbf_pkg::CNT_W-1:0]     rx_dropped;
    logic [lgdbf_pkg::CNT_W-1:0]     tx_dropped;
    logic [lgdbf_pkg::CNT_W-1:0]     tx_queued_total;
    logic [lgdbf_pkg::CNT_W-1:0]     tx_sent_total;

    modport source (output valid, ok, data_out, link_state, rx_user, rx_level, tx_level,
                    rx_dropped, tx_dropped, tx_queued_total, tx_sent_total,
                    input ready);
    modport sink   (input valid, ok, data_out, link_state, rx_user, rx_level, tx_level,
                    rx_dropped, tx_dropped, tx_queued_total, tx_sent_total,
                    output ready);
endinterface

// ----- hw/rtl/link_gated_dual_byte_fifo.sv -----
// Top level of the link-gated dual byte FIFO: link phase, receive ownership, two byte rings.
// Depends on lgdbf_pkg, lgdbf_req_if, lgdbf_rsp_if, lgdbf_ram and assert_macros.svh.
`include "assert_macros.svh"

// A serial link endpoint holding a receive ring and a transmit ring of bytes, each in its own
// RAM, gated by the link phase and by which owner holds the receive side. Every request gives
// exactly one response carrying ok, a data byte and the status and counters as they stand
// after the request. Most requests complete at the accepting edge: the pointers, fills, flags
// and counters sit in flip-flops updated at that edge, and a push writes the RAM at that edge
// too. A console, test terminal or transfer read that succeeds, and a peek that hits, also pass
// through the fetch state, because the byte comes out of the ring RAM's registered read port in
// the cycle after the address is presented; no further request is taken in the fetch state. The
// response sits in an output register, and a new request is taken in the cycle the previous
// response is taken. Both rings start empty after reset with no clearing pass: the fill counts
// guard every read, so RAM entries are only ever read after they were written.
module link_gated_dual_byte_fifo (
    input  logic               clk,
    input  logic               rst_n,
    lgdbf_req_if.sink          req,
    lgdbf_rsp_if.source        rsp
);
    import lgdbf_pkg::*;

    // Control state.
    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    link_phase_t           phase_reg, phase_next;
    logic [RX_AW-1:0]      rx_head_reg, rx_head_next;
    logic [RX_AW-1:0]      rx_tail_reg, rx_tail_next;
    logic [RX_FW-1:0]      rx_fill_reg, rx_fill_next;
    logic [TX_AW-1:0]      tx_head_reg, tx_head_next;
    logic [TX_AW-1:0]      tx_tail_reg, tx_tail_next;
    logic [TX_FW-1:0]      tx_fill_reg, tx_fill_next;
    logic [CNT_W-1:0]      rx_drop_reg, rx_drop_next;
    logic [CNT_W-1:0]      tx_drop_reg, tx_drop_next;
    logic [CNT_W-1:0]      tx_queued_reg, tx_queued_next;
    logic [CNT_W-1:0]      tx_sent_reg, tx_sent_next;
    logic                  out_valid_reg, out_valid_next;

    // Response payload.
    logic                  ok_reg, ok_next;
    logic [BYTE_W-1:0]     data_reg, data_next;
    logic                  fetch_tx_reg, fetch_tx_next;

    // Request decode and helpers.
    action_t               act;
    logic                  accept;
    logic                  live;
    logic                  ok_c;
    owner_t                read_owner;
    logic                  rx_full;
    logic                  rx_empty;
    logic                  tx_full;
    logic [RX_AW-1:0]      rx_head_inc;
    logic [RX_AW-1:0]      rx_tail_inc;
    logic [TX_AW-1:0]      tx_tail_inc;
    logic [TX_CW-1:0]      tx_amt_c;
    logic [TX_CW-1:0]      tx_fill_c;
    logic [TX_CW-1:0]      tx_done_n;
    logic [TX_FW-1:0]      tx_room;
    logic                  exact_fit;
    logic                  peek_hit;
    logic [TX_SW-1:0]      tx_peek_sum;
    logic [TX_SW-1:0]      tx_done_sum;
    logic [TX_AW-1:0]      tx_peek_addr;
    logic [TX_AW-1:0]      tx_done_head;

    // RAM ports.
    logic                  rx_we, rx_re;
    logic                  tx_we, tx_re;
    logic [BYTE_W-1:0]     rx_rdata, tx_rdata;
    logic [TX_AW-1:0]      tx_raddr;

    assign act    = action_t'(req.action);
    assign accept = req.valid && req.ready;
    assign live   = mode_reg.enabled && mode_reg.connected;

    assign rx_full  = (rx_fill_reg == RX_FW'(RX_DEPTH));
    assign rx_empty = (rx_fill_reg == '0);
    assign tx_full  = (tx_fill_reg == TX_FW'(TX_DEPTH));

    assign rx_head_inc = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + RX_AW'(1);
    assign rx_tail_inc = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + RX_AW'(1);
    assign tx_tail_inc = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + TX_AW'(1);

    // Transmit lengths: the send completion is clamped to the fill, and both the peek offset
    // and the clamped length stay below twice the depth once added to the head, so a single
    // compare and subtract wraps them.
    assign tx_amt_c  = TX_CW'(req.amount);
    assign tx_fill_c = TX_CW'(tx_fill_reg);
    assign tx_done_n = (tx_amt_c > tx_fill_c) ? tx_fill_c : tx_amt_c;
    assign tx_room   = TX_FW'(TX_DEPTH) - tx_fill_reg;
    assign exact_fit = (tx_amt_c <= TX_CW'(tx_room));
    assign peek_hit  = (tx_amt_c < tx_fill_c);

    assign tx_peek_sum  = TX_SW'(tx_head_reg) + TX_SW'(req.amount);
    assign tx_done_sum  = TX_SW'(tx_head_reg) + TX_SW'(tx_done_n);
    assign tx_peek_addr = (tx_peek_sum >= TX_SW'(TX_DEPTH))
                        ? TX_AW'(tx_peek_sum - TX_SW'(TX_DEPTH)) : TX_AW'(tx_peek_sum);
    assign tx_done_head = (tx_done_sum >= TX_SW'(TX_DEPTH))
                        ? TX_AW'(tx_done_sum - TX_SW'(TX_DEPTH)) : TX_AW'(tx_done_sum);

    // Which owner a read action stands for.
    always_comb
    begin
        case (act)
            ACT_READ_CON:  read_owner = OWN_CONSOLE;
            ACT_READ_TEST: read_owner = OWN_TEST;
            ACT_READ_XFER: read_owner = OWN_XFER;
            default:       read_owner = OWN_NONE;
        endcase
    end

    // Request execution: every state update happens at the accepting edge. A receive clear
    // simply drops both pointers and the fill; the RAM contents are left as they are.
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_fill_next   = rx_fill_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_fill_next   = tx_fill_reg;
        rx_drop_next   = rx_drop_reg;
        tx_drop_next   = tx_drop_reg;
        tx_queued_next = tx_queued_reg;
        tx_sent_next   = tx_sent_reg;
        ok_c           = 1'b0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        tx_we          = 1'b0;
        tx_re          = 1'b0;
        tx_raddr       = tx_peek_addr;

        if (accept)
        begin
            case (act)
                ACT_ENABLE:
                begin
                    rx_head_next     = '0;
                    rx_tail_next     = '0;
                    rx_fill_next     = '0;
                    tx_head_next     = '0;
                    tx_tail_next     = '0;
                    tx_fill_next     = '0;
                    rx_drop_next     = '0;
                    tx_drop_next     = '0;
                    tx_queued_next   = '0;
                    tx_sent_next     = '0;
                    mode_next        = '0;
                    mode_next.enabled = 1'b1;
                    phase_next       = PH_READY;
                    ok_c             = 1'b1;
                end
                ACT_DISABLE:
                begin
                    rx_head_next = '0;
                    rx_tail_next = '0;
                    rx_fill_next = '0;
                    tx_head_next = '0;
                    tx_tail_next = '0;
                    tx_fill_next = '0;
                    mode_next    = '0;
                    phase_next   = PH_OFF;
                    ok_c         = 1'b1;
                end
                ACT_DISC:
                begin
                    if (mode_reg.enabled && !mode_reg.connected)
                    begin
                        phase_next = PH_DISC;
                        ok_c       = 1'b1;
                    end
                end
                ACT_CONNECT:
                begin
                    if (mode_reg.enabled)
                    begin
                        rx_head_next        = '0;
                        rx_tail_next        = '0;
                        rx_fill_next        = '0;
                        tx_head_next        = '0;
                        tx_tail_next        = '0;
                        tx_fill_next        = '0;
                        mode_next.transfer  = 1'b0;
                        mode_next.connected = req.flag;
                        phase_next          = req.flag ? PH_CONN : PH_DISC;
                        ok_c                = 1'b1;
                    end
                end
                ACT_ERROR:
                begin
                    rx_head_next        = '0;
                    rx_tail_next        = '0;
                    rx_fill_next        = '0;
                    tx_head_next        = '0;
                    tx_tail_next        = '0;
                    tx_fill_next        = '0;
                    mode_next.transfer  = 1'b0;
                    mode_next.connected = 1'b0;
                    phase_next          = mode_reg.enabled ? PH_ERROR : PH_OFF;
                    ok_c                = 1'b1;
                end
                ACT_RX_PUSH:
                begin
                    if (live)
                    begin
                        if (!rx_full)
                        begin
                            rx_we        = 1'b1;
                            rx_tail_next = rx_tail_inc;
                            rx_fill_next = rx_fill_reg + RX_FW'(1);
                            ok_c         = 1'b1;
                        end
                        else
                        begin
                            rx_drop_next = rx_drop_reg + CNT_W'(1);
                        end
                    end
                end
                ACT_CONSOLE:
                begin
                    if (!(req.flag && !mode_reg.enabled))
                    begin
                        if (mode_reg.console != req.flag)
                        begin
                            rx_head_next = '0;
                            rx_tail_next = '0;
                            rx_fill_next = '0;
                        end
                        mode_next.console = req.flag;
                        ok_c              = 1'b1;
                    end
                end
                ACT_TEST:
                begin
                    if (!(req.flag && mode_reg.transfer))
                    begin
                        if (mode_reg.test != req.flag)
                        begin
                            rx_head_next = '0;
                            rx_tail_next = '0;
                            rx_fill_next = '0;
                        end
                        mode_next.test = mode_reg.enabled && req.flag;
                        ok_c           = 1'b1;
                    end
                end
                ACT_BEGIN:
                begin
                    if (live && !mode_reg.test && !mode_reg.transfer)
                    begin
                        rx_head_next       = '0;
                        rx_tail_next       = '0;
                        rx_fill_next       = '0;
                        mode_next.transfer = 1'b1;
                        ok_c               = 1'b1;
                    end
                end
                ACT_END:
                begin
                    if (mode_reg.transfer)
                    begin
                        rx_head_next       = '0;
                        rx_tail_next       = '0;
                        rx_fill_next       = '0;
                        mode_next.transfer = 1'b0;
                        ok_c               = 1'b1;
                    end
                end
                ACT_READ_CON, ACT_READ_TEST, ACT_READ_XFER:
                begin
                    if ((owner_of(mode_reg) == read_owner) && !rx_empty)
                    begin
                        rx_re        = 1'b1;
                        rx_head_next = rx_head_inc;
                        rx_fill_next = rx_fill_reg - RX_FW'(1);
                        ok_c         = 1'b1;
                    end
                end
                ACT_TX_PUSH:
                begin
                    if (live)
                    begin
                        if (!tx_full)
                        begin
                            tx_we          = 1'b1;
                            tx_tail_next   = tx_tail_inc;
                            tx_fill_next   = tx_fill_reg + TX_FW'(1);
                            tx_queued_next = tx_queued_reg + CNT_W'(1);
                            ok_c           = 1'b1;
                        end
                        else
                        begin
                            tx_drop_next = tx_drop_reg + CNT_W'(1);
                        end
                    end
                end
                ACT_EXACT:
                begin
                    ok_c = live && exact_fit;
                end
                ACT_PEEK:
                begin
                    if (peek_hit)
                    begin
                        tx_re = 1'b1;
                        ok_c  = 1'b1;
                    end
                end
                ACT_DONE:
                begin
                    tx_head_next = tx_done_head;
                    tx_fill_next = tx_fill_reg - TX_FW'(tx_done_n);
                    tx_sent_next = tx_sent_reg + CNT_W'(tx_done_n);
                    ok_c         = 1'b1;
                end
                default:
                begin
                    ok_c = 1'b0;
                end
            endcase
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (rx_re || tx_re))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs. A request is taken only when idle and the response register is
    // free or being emptied in this cycle.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  req.ready = !out_valid_reg || rsp.ready;
            ST_FETCH: req.ready = 1'b0;
            default:  req.ready = 1'b0;
        endcase
    end

    // Response register. A fetching request leaves it empty in the fetch state and fills it with
    // the byte from the RAM; ok was already set when the request was accepted.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        data_next      = data_reg;
        fetch_tx_next  = fetch_tx_reg;
        if (state_reg == ST_FETCH)
        begin
            out_valid_next = 1'b1;
            data_next      = fetch_tx_reg ? tx_rdata : rx_rdata;
        end
        else if (accept)
        begin
            out_valid_next = !(rx_re || tx_re);
            ok_next        = ok_c;
            data_next      = '0;
            fetch_tx_next  = tx_re;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            phase_reg     <= PH_OFF;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_fill_reg   <= '0;
            rx_drop_reg   <= '0;
            tx_drop_reg   <= '0;
            tx_queued_reg <= '0;
            tx_sent_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_fill_reg   <= rx_fill_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_fill_reg   <= tx_fill_next;
            rx_drop_reg   <= rx_drop_next;
            tx_drop_reg   <= tx_drop_next;
            tx_queued_reg <= tx_queued_next;
            tx_sent_reg   <= tx_sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        data_reg     <= data_next;
        fetch_tx_reg <= fetch_tx_next;
    end

    // Receive ring: written at the tail, read at the head.
    lgdbf_ram #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_tail_reg),
        .wdata (req.data_byte),
        .re    (rx_re),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    // Transmit ring: written at the tail, peeked at head plus offset.
    lgdbf_ram #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_tail_reg),
        .wdata (req.data_byte),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // The status fields are read straight from the state, which holds still while a response
    // waits, since no request is taken until that response goes.
    assign rsp.valid           = out_valid_reg;
    assign rsp.ok              = ok_reg;
    assign rsp.data_out        = data_reg;
    assign rsp.link_state      = phase_reg;
    assign rsp.rx_user         = owner_of(mode_reg);
    assign rsp.rx_level        = LVL_W'(rx_fill_reg);
    assign rsp.tx_level        = LVL_W'(tx_fill_reg);
    assign rsp.rx_dropped      = rx_drop_reg;
    assign rsp.tx_dropped      = tx_drop_reg;
    assign rsp.tx_queued_total = tx_queued_reg;
    assign rsp.tx_sent_total   = tx_sent_reg;

    `LGDBF_ASSERT(a_fetch_delivers, (state_reg == ST_FETCH) |=> rsp.valid, "fetched byte not delivered")
    `LGDBF_ASSERT(a_fetch_blocks, (state_reg == ST_FETCH) |-> !req.ready, "request taken during fetch")
    `LGDBF_ASSERT(a_no_overwrite, (out_valid_reg && !rsp.ready) |-> !req.ready, "waiting response at risk")
    `LGDBF_ASSERT_ALWAYS(a_fill_bound, (rx_fill_reg <= RX_FW'(RX_DEPTH)) && (tx_fill_reg <= TX_FW'(TX_DEPTH)), "fill beyond depth")

endmodule

// ----- hw/rtl/lgdbf_ram.sv -----
// Byte store RAM: one write port and one read port with registered read data.
// Depends on lgdbf_pkg for the byte width.
module lgdbf_ram #(
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [$clog2(DEPTH)-1:0]             waddr,
    input  logic [lgdbf_pkg::BYTE_W-1:0]         wdata,
    input  logic                                 re,
    input  logic [$clog2(DEPTH)-1:0]             raddr,
    output logic [lgdbf_pkg::BYTE_W-1:0]         rdata
);
    import lgdbf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
